### rtl/core/rpn_pkg.sv
// shared types and constants for the rpn stack calculator
// no dependencies
package rpn_pkg;

	localparam int Depth = 256;
	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam int DataW = 32;

	typedef enum logic [2:0] {
		FN_PUSH  = 3'd0,
		FN_POP   = 3'd1,
		FN_ADD   = 3'd2,
		FN_SUB   = 3'd3,
		FN_MUL   = 3'd4,
		FN_DIV   = 3'd5,
		FN_SQRT  = 3'd6,
		FN_CLEAR = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNDER   = 3'd1,
		ST_OVER    = 3'd2,
		ST_DIVZ    = 3'd3,
		ST_NEGROOT = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RDA, S_RDB, S_LOAD, S_LATCH, S_MUL, S_ITER, S_FIX, S_WRITE, S_OUT
	} state_t;

	// start request to the iterative unit
	typedef struct packed {
		logic start;
		logic is_sqrt;
	} iter_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_sts_t;

endpackage

### rtl/core/rpn_stack_ram.sv
// stack storage, one write port and one registered read port
// depends on rpn_pkg
module rpn_stack_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [rpn_pkg::PtrW-1:0]  waddr,
	input  logic [rpn_pkg::DataW-1:0] wdata,
	input  logic [rpn_pkg::PtrW-1:0]  raddr,
	output logic [rpn_pkg::DataW-1:0] rdata
);

	logic [rpn_pkg::DataW-1:0] mem [rpn_pkg::Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/rpn_iter_unit.sv
// bit-serial unsigned divider and integer square root, one bit per cycle
// depends on rpn_pkg
module rpn_iter_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rpn_pkg::iter_ctl_t        ctl,
	input  logic [rpn_pkg::DataW-1:0] num,
	input  logic [rpn_pkg::DataW-1:0] den,
	output rpn_pkg::iter_sts_t        sts,
	output logic [rpn_pkg::DataW-1:0] result
);

	localparam int W = rpn_pkg::DataW;

	logic         busy_q, done_q, sqrt_q;
	logic [5:0]   cnt_q;
	logic [W-1:0] num_q, den_q, quo_q;
	logic [W+1:0] rem_q;

	logic [W+1:0] rem_sh, trial;
	logic         fits;

	// division shifts one numerator bit in, root shifts two
	always_comb begin
		if (sqrt_q) begin
			rem_sh = {rem_q[W-1:0], num_q[W-1:W-2]};
			trial  = {quo_q, 2'b01};
		end else begin
			rem_sh = {rem_q[W:0], num_q[W-1]};
			trial  = {2'b00, den_q};
		end
		fits = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.is_sqrt ? 6'd16 : 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			sqrt_q <= ctl.is_sqrt;
			num_q  <= num;
			den_q  <= den;
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			num_q <= sqrt_q ? {num_q[W-3:0], 2'b00} : {num_q[W-2:0], 1'b0};
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? rem_sh - trial : rem_sh;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = quo_q;

endmodule

### rtl/core/rpn_stack_calculator.sv
// top level of the rpn stack calculator: control sequencer, alu and stack memory
// depends on rpn_pkg, rpn_stack_ram and rpn_iter_unit
//
// usage:
//   s_axis carries one command per transaction: tdata[2:0] func, tdata[34:3]
//   operand, bits above zero. m_axis returns one result per command:
//   tdata[31:0] value, tdata[34:32] status, tdata[43:35] depth after the command.
//   the block works on one command at a time; s_tready is high only while idle.
//   push and clear go straight to the write state, pop and sqrt read one operand
//   and the other commands two. the two operand reads go one after another
//   through the single read port of the stack memory, with a load state for the
//   last read data to land. mul passes through its own state; division and square
//   root run through a shared bit-serial unit producing one quotient bit or one
//   root bit per cycle, then a fix state; divide by zero and negative root skip it.
//   a result is held in the output register until m_tready; the next command
//   is taken in the cycle after the result transaction.
//   reset clears the entry count and control; stack memory contents are not
//   cleared, since only entries below the count are ever read.
module rpn_stack_calculator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // func[2:0], operand[34:3]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // value[31:0], status[34:32], depth[43:35]
);

	localparam int W = rpn_pkg::DataW;
	localparam int PW = rpn_pkg::PtrW;
	localparam int CW = rpn_pkg::CntW;

	rpn_pkg::state_t state_q, state_d;

	// command registers
	rpn_pkg::func_t    func_q;
	logic [W-1:0]      opnd_q;
	logic [CW-1:0]     count_q;
	logic [W-1:0]      a_q, b_q, val_q;
	logic              under_q;
	rpn_pkg::status_t  status_q;
	logic [W-1:0]      prod_q;

	// memory port
	logic          ram_we;
	logic [PW-1:0] ram_waddr, ram_raddr;
	logic [W-1:0]  ram_wdata, ram_rdata;
	logic          rd_pend_q;  // read data on the port is valid and targets a or b
	logic          rd_b_q;

	// divider and square root unit
	rpn_pkg::iter_ctl_t iter_ctl;
	rpn_pkg::iter_sts_t iter_sts;
	logic [W-1:0]       iter_res;
	logic               na, nb;

	logic accept_in, accept_out;
	assign accept_in  = s_tvalid && s_tready;
	assign accept_out = m_tvalid && m_tready;
	assign s_tready   = (state_q == rpn_pkg::S_IDLE);
	assign m_tvalid   = (state_q == rpn_pkg::S_OUT);
	assign m_tdata    = {4'd0, count_q, status_q, val_q};

	assign na = a_q[W-1];
	assign nb = b_q[W-1];

	rpn_stack_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rpn_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (iter_ctl),
		.num    (na ? W'(0) - a_q : a_q),
		.den    (nb ? W'(0) - b_q : b_q),
		.sts    (iter_sts),
		.result (iter_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpn_pkg::S_IDLE: begin
				if (accept_in) begin
					unique case (rpn_pkg::func_t'(s_tdata[2:0]))
						rpn_pkg::FN_PUSH, rpn_pkg::FN_CLEAR: state_d = rpn_pkg::S_WRITE;
						default: state_d = rpn_pkg::S_RDA;
					endcase
				end
			end
			rpn_pkg::S_RDA: begin
				if (func_q == rpn_pkg::FN_POP || func_q == rpn_pkg::FN_SQRT) begin
					state_d = rpn_pkg::S_LOAD;
				end else begin
					state_d = rpn_pkg::S_RDB;
				end
			end
			rpn_pkg::S_RDB: state_d = rpn_pkg::S_LOAD;
			// last read data lands in a or b
			rpn_pkg::S_LOAD: state_d = rpn_pkg::S_LATCH;
			rpn_pkg::S_LATCH: begin
				priority case (func_q)
					rpn_pkg::FN_MUL: state_d = rpn_pkg::S_MUL;
					rpn_pkg::FN_DIV: begin
						state_d = (b_q != '0) ? rpn_pkg::S_ITER : rpn_pkg::S_WRITE;
					end
					rpn_pkg::FN_SQRT: begin
						state_d = a_q[W-1] ? rpn_pkg::S_WRITE : rpn_pkg::S_ITER;
					end
					default: state_d = rpn_pkg::S_WRITE;
				endcase
			end
			rpn_pkg::S_MUL: state_d = rpn_pkg::S_WRITE;
			rpn_pkg::S_ITER: begin
				if (iter_sts.done) begin
					state_d = rpn_pkg::S_FIX;
				end
			end
			rpn_pkg::S_FIX: state_d = rpn_pkg::S_WRITE;
			rpn_pkg::S_WRITE: state_d = rpn_pkg::S_OUT;
			rpn_pkg::S_OUT: begin
				if (accept_out) begin
					state_d = rpn_pkg::S_IDLE;
				end
			end
			default: state_d = rpn_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer: memory port and iterative unit start
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[PW-1:0];
		ram_wdata = val_q;
		ram_raddr = count_q[PW-1:0] - PW'(1);
		iter_ctl  = '0;
		unique case (state_q)
			rpn_pkg::S_WRITE: begin
				if (func_q == rpn_pkg::FN_PUSH) begin
					ram_wdata = opnd_q;
					ram_we    = (count_q < CW'(rpn_pkg::Depth));
				end else if (func_q != rpn_pkg::FN_POP && func_q != rpn_pkg::FN_CLEAR) begin
					ram_we = 1'b1;
				end
			end
			rpn_pkg::S_LATCH: begin
				iter_ctl.start   = (func_q == rpn_pkg::FN_DIV && b_q != '0)
					|| (func_q == rpn_pkg::FN_SQRT && !a_q[W-1]);
				iter_ctl.is_sqrt = (func_q == rpn_pkg::FN_SQRT);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rpn_pkg::S_IDLE;
			count_q   <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= 1'b0;
			if (state_q == rpn_pkg::S_RDA || state_q == rpn_pkg::S_RDB) begin
				// pop one entry per read; an empty stack marks underflow
				if (count_q != '0) begin
					count_q   <= count_q - CW'(1);
					rd_pend_q <= 1'b1;
				end
			end
			if (state_q == rpn_pkg::S_WRITE) begin
				if (func_q == rpn_pkg::FN_CLEAR) begin
					count_q <= '0;
				end else if (func_q == rpn_pkg::FN_PUSH) begin
					if (count_q < CW'(rpn_pkg::Depth)) begin
						count_q <= count_q + CW'(1);
					end
				end else if (func_q != rpn_pkg::FN_POP) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept_in) begin
			func_q   <= rpn_pkg::func_t'(s_tdata[2:0]);
			opnd_q   <= s_tdata[34:3];
			a_q      <= '0;
			b_q      <= '0;
			under_q  <= 1'b0;
			val_q    <= '0;
			status_q <= rpn_pkg::ST_OK;
		end
		if (state_q == rpn_pkg::S_RDA || state_q == rpn_pkg::S_RDB) begin
			rd_b_q <= (state_q == rpn_pkg::S_RDB);
			if (count_q == '0) begin
				under_q <= 1'b1;
			end
		end
		// read data from the registered read port lands while rd_pend_q is set
		if (rd_pend_q) begin
			if (rd_b_q) begin
				b_q <= ram_rdata;
			end else begin
				a_q <= ram_rdata;
			end
		end
		if (state_q == rpn_pkg::S_LATCH) begin
			priority case (func_q)
				rpn_pkg::FN_POP: val_q <= a_q;
				rpn_pkg::FN_ADD: val_q <= a_q + b_q;
				rpn_pkg::FN_SUB: val_q <= a_q - b_q;
				rpn_pkg::FN_DIV: if (b_q == '0) status_q <= rpn_pkg::ST_DIVZ;
				rpn_pkg::FN_SQRT: if (a_q[W-1]) status_q <= rpn_pkg::ST_NEGROOT;
				default: ;
			endcase
			// only the low word of the product is kept
			prod_q <= a_q * b_q;
		end
		if (state_q == rpn_pkg::S_MUL) begin
			val_q <= prod_q;
		end
		if (state_q == rpn_pkg::S_FIX && status_q == rpn_pkg::ST_OK) begin
			if (func_q == rpn_pkg::FN_DIV && na != nb) begin
				val_q <= W'(0) - iter_res;
			end else begin
				val_q <= iter_res;
			end
		end
		if (state_q == rpn_pkg::S_WRITE) begin
			if (func_q == rpn_pkg::FN_PUSH && count_q >= CW'(rpn_pkg::Depth)) begin
				status_q <= rpn_pkg::ST_OVER;
			end
			if (under_q) begin
				status_q <= rpn_pkg::ST_UNDER;
			end
		end
	end

	// the sequencer only accepts while idle, and only offers a result in the output state
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("input and output handshakes open together");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(rpn_pkg::Depth))
		else $error("entry count beyond stack depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		iter_sts.busy |-> state_q == rpn_pkg::S_ITER)
		else $error("iterative unit running outside its state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result changed while stalled");

endmodule
